/* hw/rtl/tlvp_pkg.sv */
// Shared types, codes and tables for the tag/length/value stream parser.
package tlvp_pkg;

  localparam int MAX_DEPTH_DEF = 8;

  // Parser phases, one-hot
  typedef enum logic [6:0] {
    PH_KEY     = 7'b0000001,
    PH_KEYCONT = 7'b0000010,
    PH_LEN     = 7'b0000100,
    PH_FLAG    = 7'b0001000,
    PH_VALUE   = 7'b0010000,
    PH_DONE    = 7'b0100000,
    PH_ERR     = 7'b1000000
  } phase_t;

  // Token kinds
  localparam logic [2:0] KIND_KEY     = 3'd0;
  localparam logic [2:0] KIND_VALUE   = 3'd1;
  localparam logic [2:0] KIND_LENGTH  = 3'd2;
  localparam logic [2:0] KIND_FLAG    = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;
  localparam logic [2:0] KIND_IGNORED = 3'd5;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_TYPE = 3'd1;
  localparam logic [2:0] ERR_BAD_FLAG = 3'd2;
  localparam logic [2:0] ERR_DEEP     = 3'd3;
  localparam logic [2:0] ERR_LONG     = 3'd4;
  localparam logic [2:0] ERR_LIMIT    = 3'd5;
  localparam logic [2:0] ERR_TOP_KEY  = 3'd6;
  localparam logic [2:0] ERR_EXTRA    = 3'd7;

  // Field types and special bytes
  localparam logic [3:0] TYPE_LAST_BASE = 4'd9;
  localparam logic [3:0] FTYPE_ARRAY    = 4'd10;
  localparam logic [3:0] FTYPE_OBJECT   = 4'd11;
  localparam logic [7:0] BYTE_END       = 8'h7F;
  localparam logic [7:0] BYTE_OBJ_ELEM  = 8'h02;
  localparam logic [3:0] FLAG_BASE_NIB  = 4'h1;
  localparam logic [2:0] MAX_GROUPS     = 3'd4;

  // Stack entry: array-element flag plus elements left
  typedef struct packed {
    logic        is_elem;
    logic [31:0] left;
  } level_t;

  // Byte width of a base type
  function automatic logic [3:0] base_width(input logic [3:0] t);
    logic [3:0] w;
    case (t)
      4'd0, 4'd1: w = 4'd1;
      4'd2, 4'd3: w = 4'd2;
      4'd4, 4'd5, 4'd8: w = 4'd4;
      default: w = 4'd8;
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/tlvp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tlvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/tlv_wire_stream_parser.sv */
// Top level of the schema-free tag/length/value byte stream parser.
//
// Input channel (in_valid/in_ready) carries one stream byte plus a
// frame_start mark per transaction. Each byte yields exactly one result
// transaction (out_valid/out_ready) classifying it and reporting decoded
// field number, type, array length, nesting depth, running sum and status.
// The result is registered at the edge that accepts the byte. Throughput
// is one byte per cycle while the receiver does not stall; the per-byte
// update is register logic plus a stack RAM with registered read data whose
// read is prefetched at the entry below the cached top of stack.
// The object stack lives in a RAM of MAX_DEPTH entries; the top entry is
// mirrored in flip-flops so closing a level needs no wait.
// When the receiver stalls, the result holds and in_ready drops until the
// result transaction completes; a byte is taken in the same cycle the
// waiting result leaves.
// Reset (rst, synchronous) empties the output, sets the limit register to
// all ones and puts the parser in the top-key phase. The stack needs no
// clearing pass: frame_start empties it and entries are written before read.
// The cfg channel writes stream_limit and is always ready.
module tlv_wire_stream_parser #(
  parameter int MAX_DEPTH = tlvp_pkg::MAX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  token_kind,
  output logic [7:0]  value_byte,
  output logic [31:0] field_number,
  output logic [3:0]  field_type,
  output logic [31:0] array_length,
  output logic [3:0]  nest_depth,
  output logic        token_last,
  output logic [31:0] byte_sum,
  output logic        frame_done,
  output logic [2:0]  error_code
);

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int PW = $clog2(MAX_DEPTH + 1);
  localparam logic [PW-1:0] LP_MAX = PW'(MAX_DEPTH);
  localparam logic [PW-1:0] LP_ONE = PW'(1);
  localparam logic [PW-1:0] LP_TWO = PW'(2);

  // Parser state
  tlvp_pkg::phase_t ph, ph_next;
  logic [PW-1:0] lp, lp_next;
  logic          top_elem, top_elem_next;
  logic [31:0]   top_left, top_left_next;
  logic [31:0]   acc, acc_next;
  logic [2:0]    cnt, cnt_next;
  logic [2:0]    klb, klb_next;
  logic [3:0]    ctype, ctype_next;
  logic [3:0]    vbl, vbl_next;
  logic [31:0]   bel, bel_next;
  logic [3:0]    ew, ew_next;
  logic [31:0]   pos, pos_next;
  logic [31:0]   sum, sum_next;
  logic          done, done_next;
  logic [2:0]    err, err_next;
  logic [31:0]   stream_limit;

  // Effective state after frame_start
  tlvp_pkg::phase_t ph_c;
  logic [PW-1:0] lp_c;
  logic [31:0]   pos_c, sum_c;
  logic          done_c;
  logic [2:0]    err_c;

  // Stack RAM
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  tlvp_pkg::level_t      mem_wdata, mem_rdata;
  logic [PW-1:0]         rd_lp;

  // Per-byte result
  logic [2:0]  k;
  logic [3:0]  ft;
  logic        lst;
  logic [2:0]  er;
  logic [31:0] fn, al;
  logic        push_req, push_elem, fin;
  logic [31:0] push_cnt, grp, v_left, b_left;
  logic [3:0]  v;
  logic        accept;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  // Prefetch the entry under the top of stack
  assign rd_lp     = accept ? lp_next : lp;
  assign mem_raddr = (rd_lp >= LP_TWO) ? AW'(rd_lp - LP_TWO) : '0;

  tlvp_ram #(
    .WIDTH ($bits(tlvp_pkg::level_t)),
    .DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next-state logic for one byte
  always_comb begin
    ph_c   = frame_start ? tlvp_pkg::PH_KEY : ph;
    lp_c   = frame_start ? '0 : lp;
    pos_c  = frame_start ? '0 : pos;
    sum_c  = frame_start ? '0 : sum;
    done_c = frame_start ? 1'b0 : done;
    err_c  = frame_start ? tlvp_pkg::ERR_NONE : err;

    ph_next       = ph_c;
    lp_next       = lp_c;
    top_elem_next = top_elem;
    top_left_next = top_left;
    acc_next      = frame_start ? '0 : acc;
    cnt_next      = frame_start ? '0 : cnt;
    klb_next      = frame_start ? '0 : klb;
    ctype_next    = frame_start ? '0 : ctype;
    vbl_next      = frame_start ? '0 : vbl;
    bel_next      = frame_start ? '0 : bel;
    ew_next       = frame_start ? '0 : ew;
    pos_next      = pos_c;
    sum_next      = sum_c;
    done_next     = done_c;
    err_next      = err_c;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;

    k         = tlvp_pkg::KIND_IGNORED;
    ft        = '0;
    lst       = 1'b0;
    er        = tlvp_pkg::ERR_NONE;
    fn        = '0;
    al        = '0;
    push_req  = 1'b0;
    push_elem = 1'b0;
    push_cnt  = '0;
    fin       = 1'b0;
    grp       = 32'({25'd0, data_byte[6:0]}) << (7 * cnt_next);
    v         = vbl_next;
    v_left    = bel_next;
    b_left    = bel_next;

    unique case (ph_c)
      tlvp_pkg::PH_KEY: begin
        if (lp_c != '0 && data_byte == tlvp_pkg::BYTE_END) begin
          k   = tlvp_pkg::KIND_END;
          lst = 1'b1;
          // close the top level
          if (top_elem && top_left > 32'd1) begin
            top_left_next = top_left - 32'd1;
            mem_we        = 1'b1;
            mem_waddr     = AW'(lp_c - LP_ONE);
            mem_wdata     = '{is_elem: 1'b1, left: top_left - 32'd1};
          end else begin
            lp_next = lp_c - LP_ONE;
            if (lp_c != LP_ONE) begin
              top_elem_next = mem_rdata.is_elem;
              top_left_next = mem_rdata.left;
            end else begin
              done_next = 1'b1;
              ph_next   = tlvp_pkg::PH_DONE;
            end
          end
        end else if (data_byte[3:0] > tlvp_pkg::FTYPE_OBJECT) begin
          er = tlvp_pkg::ERR_BAD_TYPE;
        end else begin
          ctype_next = data_byte[3:0];
          klb_next   = data_byte[6:4];
          acc_next   = '0;
          cnt_next   = '0;
          k          = tlvp_pkg::KIND_KEY;
          ft         = data_byte[3:0];
          if (data_byte[7]) begin
            ph_next = tlvp_pkg::PH_KEYCONT;
          end else begin
            lst = 1'b1;
            fin = 1'b1;
          end
        end
      end
      tlvp_pkg::PH_KEYCONT: begin
        if (data_byte[7] && cnt_next >= tlvp_pkg::MAX_GROUPS) begin
          er = tlvp_pkg::ERR_LONG;
        end else begin
          acc_next = acc_next | grp;
          cnt_next = cnt_next + 3'd1;
          k        = tlvp_pkg::KIND_KEY;
          ft       = ctype_next;
          if (!data_byte[7]) begin
            lst = 1'b1;
            fin = 1'b1;
          end
        end
      end
      tlvp_pkg::PH_LEN: begin
        if (data_byte[7] && cnt_next >= tlvp_pkg::MAX_GROUPS) begin
          er = tlvp_pkg::ERR_LONG;
        end else begin
          acc_next = acc_next | grp;
          cnt_next = cnt_next + 3'd1;
          k        = tlvp_pkg::KIND_LENGTH;
          if (!data_byte[7]) begin
            lst      = 1'b1;
            al       = acc_next;
            bel_next = acc_next;
            ph_next  = tlvp_pkg::PH_FLAG;
          end
        end
      end
      tlvp_pkg::PH_FLAG: begin
        k   = tlvp_pkg::KIND_FLAG;
        lst = 1'b1;
        if (data_byte[3:0] == tlvp_pkg::FLAG_BASE_NIB &&
            data_byte[7:4] <= tlvp_pkg::TYPE_LAST_BASE) begin
          if (bel_next == '0) begin
            ph_next = tlvp_pkg::PH_KEY;
          end else begin
            ew_next  = tlvp_pkg::base_width(data_byte[7:4]);
            vbl_next = tlvp_pkg::base_width(data_byte[7:4]);
            ph_next  = tlvp_pkg::PH_VALUE;
          end
        end else if (data_byte == tlvp_pkg::BYTE_OBJ_ELEM) begin
          if (bel_next == '0) begin
            ph_next = tlvp_pkg::PH_KEY;
          end else begin
            push_req  = 1'b1;
            push_elem = 1'b1;
            push_cnt  = bel_next;
          end
        end else begin
          er = tlvp_pkg::ERR_BAD_FLAG;
        end
      end
      tlvp_pkg::PH_VALUE: begin
        if (vbl_next == ew_next &&
            ({1'b0, pos_c} + 33'(ew_next)) > {1'b0, stream_limit}) begin
          er = tlvp_pkg::ERR_LIMIT;
        end else begin
          k = tlvp_pkg::KIND_VALUE;
          if (v != '0) begin
            v = v - 4'd1;
          end
          if (v == '0) begin
            lst = 1'b1;
            if (b_left != '0) begin
              b_left = b_left - 32'd1;
            end
            v_left = b_left;
            if (b_left == '0) begin
              ph_next = tlvp_pkg::PH_KEY;
            end else begin
              v = ew_next;
            end
          end
          vbl_next = v;
          bel_next = v_left;
        end
      end
      tlvp_pkg::PH_DONE: begin
        er = tlvp_pkg::ERR_EXTRA;
      end
      tlvp_pkg::PH_ERR: begin
      end
      default: begin
      end
    endcase

    // last key byte: field number and type action
    if (fin) begin
      fn = {acc_next[28:0], klb_next};
      if (lp_c == '0) begin
        if (ctype_next != tlvp_pkg::FTYPE_OBJECT || fn != '0) begin
          er = tlvp_pkg::ERR_TOP_KEY;
        end else begin
          push_req = 1'b1;
        end
      end else if (ctype_next <= tlvp_pkg::TYPE_LAST_BASE) begin
        ew_next  = tlvp_pkg::base_width(ctype_next);
        vbl_next = tlvp_pkg::base_width(ctype_next);
        bel_next = 32'd1;
        ph_next  = tlvp_pkg::PH_VALUE;
      end else if (ctype_next == tlvp_pkg::FTYPE_ARRAY) begin
        acc_next = '0;
        cnt_next = '0;
        ph_next  = tlvp_pkg::PH_LEN;
      end else begin
        push_req = 1'b1;
      end
    end

    // open a level
    if (push_req) begin
      if (lp_c >= LP_MAX) begin
        er = tlvp_pkg::ERR_DEEP;
      end else begin
        mem_we        = 1'b1;
        mem_waddr     = AW'(lp_c);
        mem_wdata     = '{is_elem: push_elem, left: push_cnt};
        top_elem_next = push_elem;
        top_left_next = push_cnt;
        lp_next       = lp_c + LP_ONE;
        ph_next       = tlvp_pkg::PH_KEY;
      end
    end

    // error and consumption
    if (er != tlvp_pkg::ERR_NONE) begin
      err_next = er;
      ph_next  = tlvp_pkg::PH_ERR;
    end
    if (er != tlvp_pkg::ERR_NONE || ph_c == tlvp_pkg::PH_ERR) begin
      k   = tlvp_pkg::KIND_IGNORED;
      fn  = '0;
      ft  = '0;
      al  = '0;
      lst = 1'b0;
    end else begin
      pos_next = pos_c + 32'd1;
      sum_next = sum_c + 32'(data_byte);
    end

    if (!accept) begin
      mem_we = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ph           <= tlvp_pkg::PH_KEY;
      lp           <= '0;
      acc          <= '0;
      cnt          <= '0;
      klb          <= '0;
      ctype        <= '0;
      vbl          <= '0;
      bel          <= '0;
      ew           <= '0;
      pos          <= '0;
      sum          <= '0;
      done         <= 1'b0;
      err          <= tlvp_pkg::ERR_NONE;
      stream_limit <= '1;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        stream_limit <= cfg_data;
      end
      if (accept) begin
        ph    <= ph_next;
        lp    <= lp_next;
        acc   <= acc_next;
        cnt   <= cnt_next;
        klb   <= klb_next;
        ctype <= ctype_next;
        vbl   <= vbl_next;
        bel   <= bel_next;
        ew    <= ew_next;
        pos   <= pos_next;
        sum   <= sum_next;
        done  <= done_next;
        err   <= err_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Cached top of stack and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      top_elem     <= top_elem_next;
      top_left     <= top_left_next;
      token_kind   <= k;
      value_byte   <= data_byte;
      field_number <= fn;
      field_type   <= ft;
      array_length <= al;
      nest_depth   <= 4'(lp_next);
      token_last   <= lst;
      byte_sum     <= sum_next;
      frame_done   <= done_next;
      error_code   <= err_next;
    end
  end

endmodule

/* hw/rtl/tlvp_checker.sv */
// Port-level assertions for the stream parser, bound to its top level.
module tlvp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  token_kind,
  input logic        token_last,
  input logic [31:0] byte_sum,
  input logic [2:0]  error_code
);

  // ignored bytes only come with a recorded error
  a_ignored_has_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == tlvp_pkg::KIND_IGNORED |-> error_code != tlvp_pkg::ERR_NONE)
    else $error("ignored token without error");

  // end bytes are single-byte tokens
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == tlvp_pkg::KIND_END |-> token_last)
    else $error("end token without last");

  // empty output register always takes a byte
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_sum))
    else $error("stalled result changed");

endmodule

bind tlv_wire_stream_parser tlvp_checker u_tlvp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .token_kind (token_kind),
  .token_last (token_last),
  .byte_sum   (byte_sum),
  .error_code (error_code)
);

/* tb/tb_top.sv */
// Self-checking testbench for the tag/length/value stream parser top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DEPTH = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  token_kind;
  logic [7:0]  value_byte;
  logic [31:0] field_number;
  logic [3:0]  field_type;
  logic [31:0] array_length;
  logic [3:0]  nest_depth;
  logic        token_last;
  logic [31:0] byte_sum;
  logic        frame_done;
  logic [2:0]  error_code;

  tlv_wire_stream_parser #(.MAX_DEPTH(DEPTH)) dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One expected result transaction
  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  vbyte;
    logic [31:0] fnum;
    logic [3:0]  ftype;
    logic [31:0] alen;
    logic [3:0]  depth;
    logic        last;
    logic [31:0] sum;
    logic        done;
    logic [2:0]  err;
  } token_t;

  token_t token_q[$];
  logic [7:0] stream_q[$];
  int mismatches = 0;
  int bytes_sent = 0;
  int tokens_seen = 0;
  int frames_sent = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int rx_hold = 0;
  int rx_stall = 0;

  // Parser shadow state
  logic [31:0]      limit_reg;
  tlvp_pkg::phase_t ph;
  int               lvl;
  bit               lvl_elem[DEPTH];
  logic [31:0]      lvl_left[DEPTH];
  logic [31:0]      acc;
  int               grp;
  logic [2:0]       klow;
  logic [3:0]       ctype;
  int               vleft;
  logic [31:0]      belems;
  int               ewidth;
  logic [31:0]      pos;
  logic [31:0]      sum;
  bit               done;
  logic [2:0]       serr;

  function automatic int width_of(input logic [3:0] t);
    case (t)
      0, 1: return 1;
      2, 3: return 2;
      4, 5, 8: return 4;
      default: return 8;
    endcase
  endfunction

  function automatic void clear_frame();
    ph = tlvp_pkg::PH_KEY;
    lvl = 0;
    for (int i = 0; i < DEPTH; i++) begin
      lvl_elem[i] = 0;
      lvl_left[i] = '0;
    end
    acc = '0; grp = 0; klow = '0; ctype = '0; vleft = 0;
    belems = '0; ewidth = 0; pos = '0; sum = '0; done = 0; serr = tlvp_pkg::ERR_NONE;
  endfunction

  function automatic logic [2:0] open_level(input bit elem, input logic [31:0] count);
    if (lvl >= DEPTH) return tlvp_pkg::ERR_DEEP;
    lvl_elem[lvl] = elem;
    lvl_left[lvl] = count;
    lvl++;
    ph = tlvp_pkg::PH_KEY;
    return tlvp_pkg::ERR_NONE;
  endfunction

  function automatic logic [2:0] key_done(output logic [31:0] fn);
    fn = {acc[28:0], klow};
    if (lvl == 0) begin
      if (ctype != tlvp_pkg::FTYPE_OBJECT || fn != 0) return tlvp_pkg::ERR_TOP_KEY;
      return open_level(0, '0);
    end
    if (ctype <= tlvp_pkg::TYPE_LAST_BASE) begin
      ewidth = width_of(ctype);
      vleft = ewidth;
      belems = 1;
      ph = tlvp_pkg::PH_VALUE;
      return tlvp_pkg::ERR_NONE;
    end
    if (ctype == tlvp_pkg::FTYPE_ARRAY) begin
      acc = '0;
      grp = 0;
      ph = tlvp_pkg::PH_LEN;
      return tlvp_pkg::ERR_NONE;
    end
    return open_level(0, '0);
  endfunction

  function automatic void close_level();
    if (lvl == 0) return;
    if (lvl_elem[lvl-1] && lvl_left[lvl-1] > 1) begin
      lvl_left[lvl-1]--;
      return;
    end
    lvl--;
    if (lvl == 0) begin
      done = 1;
      ph = tlvp_pkg::PH_DONE;
    end
  endfunction

  function automatic void add_group(input logic [7:0] b);
    logic [63:0] g;
    g = 64'(b[6:0]) << (7 * (grp & 7));
    acc = acc | g[31:0];
    grp++;
  endfunction

  // Expected result for one accepted byte
  function automatic token_t parse_byte(input logic [7:0] b, input logic fs);
    token_t r;
    logic [2:0] kind, err;
    logic [3:0] ft;
    logic [31:0] fn, al;
    logic lst;
    kind = tlvp_pkg::KIND_IGNORED; err = tlvp_pkg::ERR_NONE;
    ft = '0; fn = '0; al = '0; lst = 0;
    if (fs) clear_frame();
    case (ph)
      tlvp_pkg::PH_KEY: begin
        if (lvl > 0 && b == tlvp_pkg::BYTE_END) begin
          kind = tlvp_pkg::KIND_END; lst = 1;
          close_level();
        end else if (b[3:0] > tlvp_pkg::FTYPE_OBJECT) begin
          err = tlvp_pkg::ERR_BAD_TYPE;
        end else begin
          ctype = b[3:0]; klow = b[6:4]; acc = '0; grp = 0;
          kind = tlvp_pkg::KIND_KEY; ft = ctype;
          if (b[7]) ph = tlvp_pkg::PH_KEYCONT;
          else begin
            lst = 1;
            err = key_done(fn);
          end
        end
      end
      tlvp_pkg::PH_KEYCONT: begin
        if (b[7] && grp >= 4) err = tlvp_pkg::ERR_LONG;
        else begin
          add_group(b);
          kind = tlvp_pkg::KIND_KEY; ft = ctype;
          if (!b[7]) begin
            lst = 1;
            err = key_done(fn);
          end
        end
      end
      tlvp_pkg::PH_LEN: begin
        if (b[7] && grp >= 4) err = tlvp_pkg::ERR_LONG;
        else begin
          add_group(b);
          kind = tlvp_pkg::KIND_LENGTH;
          if (!b[7]) begin
            lst = 1; al = acc; belems = acc; ph = tlvp_pkg::PH_FLAG;
          end
        end
      end
      tlvp_pkg::PH_FLAG: begin
        kind = tlvp_pkg::KIND_FLAG; lst = 1;
        if (b[3:0] == tlvp_pkg::FLAG_BASE_NIB && b[7:4] <= tlvp_pkg::TYPE_LAST_BASE) begin
          if (belems == 0) ph = tlvp_pkg::PH_KEY;
          else begin
            ewidth = width_of(b[7:4]); vleft = ewidth; ph = tlvp_pkg::PH_VALUE;
          end
        end else if (b == tlvp_pkg::BYTE_OBJ_ELEM) begin
          if (belems == 0) ph = tlvp_pkg::PH_KEY;
          else err = open_level(1, belems);
        end else err = tlvp_pkg::ERR_BAD_FLAG;
      end
      tlvp_pkg::PH_VALUE: begin
        if (vleft == ewidth && 64'(pos) + 64'(ewidth) > 64'(limit_reg)) begin
          err = tlvp_pkg::ERR_LIMIT;
        end else begin
          kind = tlvp_pkg::KIND_VALUE;
          if (vleft > 0) vleft--;
          if (vleft == 0) begin
            lst = 1;
            if (belems > 0) belems--;
            if (belems == 0) ph = tlvp_pkg::PH_KEY;
            else vleft = ewidth;
          end
        end
      end
      tlvp_pkg::PH_DONE: err = tlvp_pkg::ERR_EXTRA;
      default: ;
    endcase
    if (err != tlvp_pkg::ERR_NONE) begin
      serr = err;
      ph = tlvp_pkg::PH_ERR;
    end
    if (err != tlvp_pkg::ERR_NONE || ph == tlvp_pkg::PH_ERR) begin
      kind = tlvp_pkg::KIND_IGNORED; fn = '0; ft = '0; al = '0; lst = 0;
    end else begin
      pos++;
      sum += 32'(b);
    end
    r.kind = kind; r.vbyte = b; r.fnum = fn; r.ftype = ft; r.alen = al;
    r.depth = 4'(lvl); r.last = lst; r.sum = sum; r.done = done; r.err = serr;
    return r;
  endfunction

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      rx_stall = $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    token_t e;
    if (!rst && out_valid && out_ready) begin
      tokens_seen++;
      if (token_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction, kind %0d", token_kind);
      end else begin
        e = token_q.pop_front();
        if (token_kind !== e.kind || value_byte !== e.vbyte || field_number !== e.fnum ||
            field_type !== e.ftype || array_length !== e.alen || nest_depth !== e.depth ||
            token_last !== e.last || byte_sum !== e.sum || frame_done !== e.done ||
            error_code !== e.err) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch on byte %h: exp kind %0d fn %0d ft %0d len %0d dep %0d",
                     e.vbyte, e.kind, e.fnum, e.ftype, e.alen, e.depth);
            $display("  last %0d sum %h done %0d err %0d", e.last, e.sum, e.done, e.err);
            $display("  got kind %0d byte %h fn %0d ft %0d len %0d dep %0d", token_kind,
                     value_byte, field_number, field_type, array_length, nest_depth);
            $display("  last %0d sum %h done %0d err %0d", token_last, byte_sum,
                     frame_done, error_code);
          end
        end
      end
    end
  end

  // Offer one byte; returns at the falling edge after it is taken, valid still high
  task automatic send_byte(input logic [7:0] b, input logic fs);
    in_valid <= 1'b1;
    data_byte <= b;
    frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    token_q.push_back(parse_byte(b, fs));
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic pause(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Send queued bytes, first one with frame_start
  task automatic send_stream(input bit gaps);
    bit first;
    first = 1;
    while (stream_q.size() > 0) begin
      send_byte(stream_q.pop_front(), first);
      if (first) frames_sent++;
      first = 0;
      if (gaps && !quiet && $urandom_range(0, 7) == 0) pause($urandom_range(1, 17));
    end
  endtask

  task automatic drain();
    pause(1);
    while (token_q.size() > 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    limit_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic put_varint(input logic [31:0] v);
    do begin
      stream_q.push_back({(v > 32'h7f), v[6:0]});
      v = v >> 7;
    end while (v != 0);
  endtask

  task automatic put_key(input logic [3:0] t, input logic [31:0] fn);
    logic [31:0] hi;
    hi = fn >> 3;
    stream_q.push_back({(hi != 0), fn[2:0], t});
    if (hi != 0) put_varint(hi);
  endtask

  task automatic put_fields(input int depth);
    int n, t, cnt, w;
    bit objs;
    n = (depth > 3) ? $urandom_range(0, 1) : $urandom_range(0, 3);
    repeat (n) begin
      t = $urandom_range(0, 11);
      if (t == 11 && depth < 9) begin
        put_key(4'(t), ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 20));
        put_fields(depth + 1);
        stream_q.push_back(tlvp_pkg::BYTE_END);
      end else if (t == 10) begin
        put_key(4'(t), $urandom_range(0, 200));
        cnt = $urandom_range(0, 3);
        put_varint(cnt);
        objs = (depth < 6) && $urandom_range(0, 2) == 0;
        if (objs) begin
          stream_q.push_back(tlvp_pkg::BYTE_OBJ_ELEM);
          repeat (cnt) begin
            put_fields(depth + 1);
            stream_q.push_back(tlvp_pkg::BYTE_END);
          end
        end else begin
          w = $urandom_range(0, 9);
          stream_q.push_back({4'(w), tlvp_pkg::FLAG_BASE_NIB});
          repeat (cnt * width_of(4'(w))) stream_q.push_back(8'($urandom()));
        end
      end else begin
        t = t % 10;
        put_key(4'(t), $urandom_range(0, 2000));
        repeat (width_of(4'(t))) stream_q.push_back(8'($urandom()));
      end
    end
  endtask

  task automatic put_frame();
    stream_q.push_back({1'b0, 3'd0, tlvp_pkg::FTYPE_OBJECT});
    put_fields(1);
    stream_q.push_back(tlvp_pkg::BYTE_END);
  endtask

  // Long field number, wide value, an empty array, end of frame, extra byte
  task automatic test_extremes();
    stream_q = '{8'h0B, 8'hF0, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'hFF,
                 8'h9A, 8'h02, 8'h01, 8'h91, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                 8'h00, 8'hFF, 8'h1A, 8'h00, 8'h02, 8'h7F, 8'h55};
    send_stream(0);
    drain();
  endtask

  // Bad type, top-level key, bad flag, over-long varint and too-deep errors, each from a fresh frame
  task automatic test_errors();
    stream_q = '{8'h7F, 8'h00}; send_stream(0);
    stream_q = '{8'h0C}; send_stream(0);
    stream_q = '{8'h1B}; send_stream(0);
    stream_q = '{8'h0B, 8'h0A, 8'h01, 8'h33}; send_stream(0);
    stream_q = '{8'h0B, 8'h8A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80}; send_stream(0);
    stream_q = '{8'h0B, 8'h0A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h81}; send_stream(0);
    repeat (DEPTH + 1) stream_q.push_back(8'h0B);
    send_stream(0);
    drain();
  endtask

  // Stream limit at its extremes and in between
  task automatic test_limit();
    write_limit(32'd0);
    stream_q = '{8'h0B, 8'h00, 8'h55}; send_stream(0);
    write_limit(32'd3);
    stream_q = '{8'h0B, 8'h00, 8'h01, 8'h02, 8'h11, 8'h02}; send_stream(0);
    write_limit(32'hFFFF_FFFF);
    stream_q = '{8'h0B, 8'h00, 8'h01, 8'h7F}; send_stream(0);
    drain();
  endtask

  // Receiver holds off while frames keep arriving back to back
  task automatic test_backpressure();
    rx_hold = 200;
    repeat (3) put_frame();
    send_stream(0);
    drain();
  endtask

  // Random frames, some corrupted, some plain noise
  task automatic test_random(input int target, input bit small_limit);
    int sel, k;
    if (small_limit) write_limit($urandom_range(8, 80));
    while (bytes_sent < target) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        repeat ($urandom_range(1, 8)) stream_q.push_back(8'($urandom()));
      end else begin
        put_frame();
        if (sel == 1 && stream_q.size() > 1) begin
          k = $urandom_range(1, stream_q.size() - 1);
          stream_q[k] = 8'($urandom());
        end
        if (sel == 2) stream_q.push_back(8'($urandom()));
      end
      send_stream(1);
      if (!quiet && $urandom_range(0, 3) == 0) pause($urandom_range(1, 17));
    end
    drain();
  endtask

  initial begin
    limit_reg = 32'hFFFF_FFFF;
    clear_frame();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_extremes();
    test_errors();
    test_limit();
    test_backpressure();
    test_random(350, 0);
    test_random(450, 1);
    write_limit(32'hFFFF_FFFF);
    quiet = 1'b1;
    test_random(650, 0);
    repeat (10) @(negedge clk);
    $display("Sent %0d bytes in %0d frames, checked %0d result transactions,",
             bytes_sent, frames_sent, tokens_seen);
    $display("with several stream limits, every error kind and receiver hold-offs");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching result transactions", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* tlv_wire_stream_parser.f */
hw/rtl/tlvp_pkg.sv
hw/rtl/tlvp_ram.sv
hw/rtl/tlv_wire_stream_parser.sv
hw/rtl/tlvp_checker.sv
tb/tb_top.sv
